### sv/fcct_pkg.sv
// fcct_pkg: shared types, codes and constants of the four-channel counter/timer
// no dependencies; used by the channel interfaces and the top level

package fcct_pkg;

  // default channel count and the most the payload can address
  localparam int NUM_CHANNELS_DEF = 4;
  localparam int MAX_CHANNELS     = 4;

  // event codes carried in the mode field
  typedef enum logic [2:0] {
    MODE_WRITE      = 3'd0,
    MODE_READ       = 3'd1,
    MODE_TICK       = 3'd2,
    MODE_EDGE       = 3'd3,
    MODE_ACK        = 3'd4,
    MODE_RETURN     = 3'd5,
    MODE_SET_ENABLE = 3'd6
  } mode_t;

  // control word bit positions
  localparam int CW_INT_EN  = 7;
  localparam int CW_COUNTER = 6;
  localparam int CW_PRE256  = 5;
  localparam int CW_RISE    = 4;
  localparam int CW_TRIGGER = 3;
  localparam int CW_TC_NEXT = 2;
  localparam int CW_RESET   = 1;
  localparam int CW_IS_CTRL = 0;

  localparam logic [7:0] VECTOR_MASK   = 8'hF8;
  localparam logic [7:0] NO_VECTOR     = 8'hFF;
  localparam logic [8:0] RELOAD_FULL   = 9'd256;
  localparam logic [8:0] PRESCALE_256  = 9'd256;
  localparam logic [8:0] PRESCALE_16   = 9'd16;

  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] channel;
    logic [7:0] data_byte;
    logic       rise_dir;
    logic       upstream_level;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [3:0] zcto_pulses;
    logic       int_request;
    logic       enable_out;
  } out_item_t;

  // per-channel state
  typedef struct packed {
    logic [7:0] control_word;
    logic [7:0] time_constant;
    logic [8:0] down_count;
    logic [7:0] prescale_count;
    logic       running;
    logic       await_tc;
    logic       irq_pending;
    logic       pulse_active;
    logic       in_service;
    logic       chain_enable;
  } chan_t;

  // power-up state of one channel: everything clear, chain enable set
  localparam chan_t CHAN_RESET = '{
    control_word:   8'd0,
    time_constant:  8'd0,
    down_count:     9'd0,
    prescale_count: 8'd0,
    running:        1'b0,
    await_tc:       1'b0,
    irq_pending:    1'b0,
    pulse_active:   1'b0,
    in_service:     1'b0,
    chain_enable:   1'b1
  };

endpackage

### sv/fcct_if.sv
// fcct_if: valid/ready channel interfaces for input events and results
// depends on fcct_pkg for the payload types

interface fcct_in_if;
  logic               valid;
  logic               ready;
  fcct_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface fcct_out_if;
  logic                valid;
  logic                ready;
  fcct_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### sv/four_channel_counter_timer.sv
// four_channel_counter_timer: counter/timer with daisy-chained vectored interrupts
// depends on fcct_pkg and the channel interfaces in fcct_if.sv
//
//  channel | direction | handshake          | payload
//  in_if   | sink      | valid/ready        | mode, channel, data_byte, rise_dir,
//          |           |                    | upstream_level
//  out_if  | source    | valid/ready        | read_data, zcto_pulses, int_request,
//          |           |                    | enable_out
//
// one transaction per clock sustained while out_if.ready stays high; each event is
// held in the input register, is applied to the channel state by one pass of logic
// and lands in the result register
// synchronous active-low reset puts every channel in its power-up state (stopped,
// counters clear, chain enables and upstream enable set) and empties both registers
// a stalled result holds in the output register; the input register then holds one
// more event, and only after that does in_if.ready drop

module four_channel_counter_timer #(
  parameter int NUM_CHANNELS = fcct_pkg::NUM_CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  fcct_in_if.sink           in_if,
  fcct_out_if.source        out_if
);

  // input register
  logic               s1_valid_r;
  fcct_pkg::in_item_t s1_item_r;

  // result register
  logic                out_valid_r;
  fcct_pkg::out_item_t out_item_r;
  fcct_pkg::out_item_t out_item_nxt;

  // block state
  fcct_pkg::chan_t chan_r   [NUM_CHANNELS];
  fcct_pkg::chan_t chan_nxt [NUM_CHANNELS];
  logic [7:0]      vector_base_r, vector_base_nxt;
  logic            upstream_r, upstream_nxt;

  // event in the input register moves on when the result slot is free
  logic advance;
  assign advance     = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || advance;

  assign out_if.valid   = out_valid_r;
  assign out_if.payload = out_item_r;

  // reload value: a time constant of zero means 256
  function automatic logic [8:0] reload_of(input logic [7:0] tc);
    return (tc == 8'd0) ? fcct_pkg::RELOAD_FULL : {1'b0, tc};
  endfunction

  // one decrement; reaching zero reloads, pulses and may raise an interrupt
  function automatic fcct_pkg::chan_t count_down(input fcct_pkg::chan_t ch);
    fcct_pkg::chan_t res;
    res = ch;
    if (ch.down_count <= 9'd1) begin
      res.down_count   = reload_of(ch.time_constant);
      res.pulse_active = 1'b1;
      if (ch.control_word[fcct_pkg::CW_INT_EN]) res.irq_pending = 1'b1;
      // one-shot: trigger-started timer stops after it fires
      if (ch.control_word[fcct_pkg::CW_TRIGGER]) res.running = 1'b0;
    end else begin
      res.down_count = ch.down_count - 9'd1;
    end
    return res;
  endfunction

  always_comb begin
    fcct_pkg::chan_t cur;
    logic            ch_ok;
    logic            sel;
    logic            found;
    logic            chain_en;
    logic [8:0]      ps_next;
    logic [8:0]      ps_limit;
    logic [7:0]      rd;
    logic            pending_any;
    logic            serviceable;
    logic [3:0]      pulses;

    for (int c = 0; c < NUM_CHANNELS; c++) chan_nxt[c] = chan_r[c];
    vector_base_nxt = vector_base_r;
    upstream_nxt    = upstream_r;
    cur             = '0;
    sel             = 1'b0;
    ps_next         = 9'd0;
    ps_limit        = 9'd0;
    rd              = 8'd0;
    found           = 1'b0;
    chain_en        = s1_item_r.upstream_level;
    ch_ok = {1'b0, s1_item_r.channel} < 3'(NUM_CHANNELS);

    if (advance) begin
      case (s1_item_r.mode)
        fcct_pkg::MODE_WRITE: begin
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            cur = chan_r[c];
            sel = ch_ok && (s1_item_r.channel == 2'(c));
            if (sel) begin
              if (cur.await_tc) begin
                // time constant byte, whatever its low bit
                cur.time_constant = s1_item_r.data_byte;
                cur.await_tc      = 1'b0;
                if (!cur.running) begin
                  cur.down_count     = reload_of(s1_item_r.data_byte);
                  cur.prescale_count = 8'd0;
                  if (cur.control_word[fcct_pkg::CW_COUNTER] ||
                      !cur.control_word[fcct_pkg::CW_TRIGGER]) cur.running = 1'b1;
                end
              end else if (!s1_item_r.data_byte[fcct_pkg::CW_IS_CTRL]) begin
                // vector base, taken on channel 0 only
                if (c == 0) vector_base_nxt = s1_item_r.data_byte & fcct_pkg::VECTOR_MASK;
              end else begin
                cur.control_word = s1_item_r.data_byte;
                cur.await_tc     = s1_item_r.data_byte[fcct_pkg::CW_TC_NEXT];
                if (s1_item_r.data_byte[fcct_pkg::CW_RESET]) begin
                  // software reset keeps in-service and the time constant
                  cur.running        = 1'b0;
                  cur.down_count     = 9'd0;
                  cur.prescale_count = 8'd0;
                  cur.irq_pending    = 1'b0;
                  cur.pulse_active   = 1'b0;
                end
              end
            end
            chan_nxt[c] = cur;
          end
        end
        fcct_pkg::MODE_READ: begin
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (ch_ok && (s1_item_r.channel == 2'(c))) rd = chan_r[c].down_count[7:0];
          end
        end
        fcct_pkg::MODE_TICK: begin
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            cur = chan_r[c];
            cur.pulse_active = 1'b0;
            if (cur.running && !cur.control_word[fcct_pkg::CW_COUNTER]) begin
              ps_limit = cur.control_word[fcct_pkg::CW_PRE256] ?
                         fcct_pkg::PRESCALE_256 : fcct_pkg::PRESCALE_16;
              ps_next  = {1'b0, cur.prescale_count} + 9'd1;
              if (ps_next >= ps_limit) begin
                cur.prescale_count = 8'd0;
                cur = count_down(cur);
              end else begin
                cur.prescale_count = ps_next[7:0];
              end
            end
            chan_nxt[c] = cur;
          end
        end
        fcct_pkg::MODE_EDGE: begin
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            cur = chan_r[c];
            sel = ch_ok && (s1_item_r.channel == 2'(c)) &&
                  (s1_item_r.rise_dir == cur.control_word[fcct_pkg::CW_RISE]);
            if (sel) begin
              if (cur.control_word[fcct_pkg::CW_COUNTER]) begin
                if (cur.running) cur = count_down(cur);
              end else if (cur.control_word[fcct_pkg::CW_TRIGGER]) begin
                // trigger start of a stopped, armed timer
                if (!cur.running && !cur.await_tc && (cur.time_constant != 8'd0)) begin
                  cur.running        = 1'b1;
                  cur.prescale_count = 8'd0;
                end
              end
            end
            chan_nxt[c] = cur;
          end
        end
        fcct_pkg::MODE_ACK: begin
          // highest-priority serviceable channel, channel 0 first
          rd = fcct_pkg::NO_VECTOR;
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (!found && chan_r[c].irq_pending && chan_r[c].chain_enable &&
                !chan_r[c].in_service) begin
              found                   = 1'b1;
              chan_nxt[c].irq_pending = 1'b0;
              chan_nxt[c].in_service  = 1'b1;
              rd = vector_base_r | {5'd0, 2'(c), 1'b0};
            end
          end
        end
        fcct_pkg::MODE_RETURN: begin
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (!found && chan_r[c].chain_enable && chan_r[c].in_service) begin
              found                  = 1'b1;
              chan_nxt[c].in_service = 1'b0;
            end
          end
        end
        fcct_pkg::MODE_SET_ENABLE: begin
          // latch the daisy chain: a busy channel blocks those below it
          upstream_nxt = s1_item_r.upstream_level;
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            chan_nxt[c].chain_enable = chain_en;
            if (chain_en && (chan_r[c].irq_pending || chan_r[c].in_service))
              chain_en = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end

    // status after the event
    pulses      = 4'd0;
    pending_any = 1'b0;
    serviceable = 1'b0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      pulses[c] = chan_nxt[c].pulse_active;
      if (chan_nxt[c].irq_pending) pending_any = 1'b1;
      if (chan_nxt[c].irq_pending && chan_nxt[c].chain_enable && !chan_nxt[c].in_service)
        serviceable = 1'b1;
    end
    out_item_nxt.read_data   = rd;
    out_item_nxt.zcto_pulses = pulses;
    out_item_nxt.int_request = upstream_nxt && serviceable;
    out_item_nxt.enable_out  = upstream_nxt && !pending_any;
  end

  // handshake registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_if.ready) s1_valid_r <= in_if.valid;
      if (advance) out_valid_r <= 1'b1;
      else if (out_if.ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) s1_item_r <= in_if.payload;
    if (advance) out_item_r <= out_item_nxt;
  end

  // channel and chain state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CHANNELS; c++) chan_r[c] <= fcct_pkg::CHAN_RESET;
      vector_base_r <= 8'd0;
      upstream_r    <= 1'b1;
    end else begin
      for (int c = 0; c < NUM_CHANNELS; c++) chan_r[c] <= chan_nxt[c];
      vector_base_r <= vector_base_nxt;
      upstream_r    <= upstream_nxt;
    end
  end

endmodule
